// File: rtl/core/sector_remap_table_macros.svh
// Assertion helpers for the RTL of the remap table.
`ifndef SECTOR_REMAP_TABLE_MACROS_SVH
`define SECTOR_REMAP_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define SRT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SRT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SRT_ASSERT(label, clk, rst, prop, msg)

`define SRT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/core/srt_pkg.sv
package srt_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int SECTOR_W      = 48;
   localparam int COUNT_W       = 32;
   localparam int USED_W        = 7;
   localparam int CSR_DATA_W    = 7;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [CSR_DATA_W-1:0] CAPACITY_RESET = 7'd64;

   typedef enum logic [1:0] {
      CMD_LOOKUP  = 2'd0,
      CMD_ADD     = 2'd1,
      CMD_REMOVE  = 2'd2,
      CMD_COMPACT = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_MISS     = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_PRESENT  = 3'd3,
      STATUS_DISABLED = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAPACITY  = 2'd0,
      CSR_LOOKUP_EN = 2'd1,
      CSR_STATS_EN  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPACT
   } state_type;

   // One table slot as it sits in the slot memory.
   typedef struct packed {
      logic                valid;
      logic [COUNT_W-1:0]  hits;
      logic [SECTOR_W-1:0] spare;
      logic [SECTOR_W-1:0] key;
   } slot_entry_type;

endpackage

// File: rtl/core/sector_remap_table.sv
// Channel   Handshake          Payload
// command   start / busy       req_command, req_sector, req_spare_sector
// result    rsp_valid strobe   rsp_status through rsp_miss_total, six fields, one per port
// config    csr_we             csr_index, csr_wdata
//
// A command beat is taken when start is high and busy is low. A lookup, add or remove walks
// the slot memory one read per cycle and strobes its result beat once every used slot has
// been checked, sooner on a hit; compaction walks every used slot the same way and takes as
// long as a search without a hit. A disabled lookup or an add to a full table strobes in
// the cycle right after acceptance. Busy drops with the strobe, so the next beat can be
// taken at the edge that ends the result cycle; the receiver cannot stall the strobe.
// Reset is synchronous and clears control state only; the slot memory needs no clearing.
module sector_remap_table
   import srt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_command,
   input  logic [SECTOR_W-1:0]    req_sector,
   input  logic [SECTOR_W-1:0]    req_spare_sector,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_status,
   output logic [SECTOR_W-1:0]    rsp_mapped_sector,
   output logic [COUNT_W-1:0]     rsp_hit_access_count,
   output logic [USED_W-1:0]      rsp_used_slots,
   output logic [COUNT_W-1:0]     rsp_hit_total,
   output logic [COUNT_W-1:0]     rsp_miss_total,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "sector_remap_table_macros.svh"

   // Slot index width, and a counter width that holds both the slot count and
   // any value of the 7-bit capacity and used-slot fields.
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = (IDX_W + 1 > USED_W) ? IDX_W + 1 : USED_W;
   localparam int ENTRY_W = $bits(slot_entry_type);

   // Configuration registers.
   logic [CSR_DATA_W-1:0] capacity_ff;
   logic                  lookup_en_ff;
   logic                  stats_en_ff;

   // Sequencer state.
   state_type             state_ff,   state_in;
   cmd_type               cmd_ff,     cmd_in;
   logic [SECTOR_W-1:0]   key_ff,     key_in;
   logic [SECTOR_W-1:0]   spare_ff,   spare_in;
   logic [CNT_W-1:0]      rd_cnt_ff,  rd_cnt_in;
   logic [CNT_W-1:0]      wr_cnt_ff,  wr_cnt_in;
   logic                  pend_ff,    pend_in;
   logic [IDX_W-1:0]      pidx_ff,    pidx_in;
   logic [USED_W-1:0]     used_ff,    used_in;
   logic [COUNT_W-1:0]    hit_tot_ff, hit_tot_in;
   logic [COUNT_W-1:0]    miss_tot_ff, miss_tot_in;

   // Result registers.
   logic                  rsp_valid_ff,  rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SECTOR_W-1:0]   rsp_mapped_ff, rsp_mapped_in;
   logic [COUNT_W-1:0]    rsp_count_ff,  rsp_count_in;
   logic [USED_W-1:0]     rsp_used_ff;
   logic [COUNT_W-1:0]    rsp_hit_tot_ff;
   logic [COUNT_W-1:0]    rsp_miss_tot_ff;

   // Slot memory port signals.
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   slot_entry_type        ram_wdata;
   logic [IDX_W-1:0]      ram_raddr;
   logic [ENTRY_W-1:0]    ram_rdata;
   slot_entry_type        rd_entry;

   logic [CNT_W-1:0]      used_cnt;
   logic [CNT_W-1:0]      cap_cnt;
   logic                  issue;
   logic                  match;

   // The whole table lives in one memory: key, spare sector, access count and
   // valid bit of a slot share a word. Only slots below the used count are
   // ever read, and every one of those has been written, so the memory needs
   // no reset.
   srt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry  = slot_entry_type'(ram_rdata);
   assign ram_raddr = rd_cnt_ff[IDX_W-1:0];

   assign used_cnt = CNT_W'(used_ff);

   // A capacity above the number of slots saturates at the slot count.
   assign cap_cnt = (CNT_W'(capacity_ff) > CNT_W'(SLOTS)) ? CNT_W'(SLOTS)
                                                         : CNT_W'(capacity_ff);

   // The walk issues one read per cycle until it reaches the used count; the
   // data of the read issued last cycle is checked in this one.
   assign issue = (rd_cnt_ff < used_cnt);
   assign match = pend_ff && rd_entry.valid && (rd_entry.key == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         lookup_en_ff <= 1'b1;
         stats_en_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CAPACITY:  capacity_ff  <= csr_wdata;
            CSR_LOOKUP_EN: lookup_en_ff <= csr_wdata[0];
            CSR_STATS_EN:  stats_en_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      spare_in      = spare_ff;
      rd_cnt_in     = rd_cnt_ff;
      wr_cnt_in     = wr_cnt_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      used_in       = used_ff;
      hit_tot_in    = hit_tot_ff;
      miss_tot_in   = miss_tot_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_mapped_in = '0;
      rsp_count_in  = '0;
      ram_we        = 1'b0;
      ram_waddr     = pidx_ff;
      ram_wdata     = rd_entry;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = cmd_type'(req_command);
               key_in    = req_sector;
               spare_in  = req_spare_sector;
               rd_cnt_in = '0;
               wr_cnt_in = '0;
               case (cmd_type'(req_command))
                  CMD_LOOKUP: begin
                     if (!lookup_en_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_DISABLED;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_ADD: begin
                     // Full is checked before the duplicate search.
                     if (used_cnt >= cap_cnt) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_REMOVE:  state_in = S_SEARCH;
                  CMD_COMPACT: state_in = S_COMPACT;
                  default: begin
                  end
               endcase
            end
         end

         S_SEARCH: begin
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               pend_in   = 1'b1;
               pidx_in   = rd_cnt_ff[IDX_W-1:0];
            end
            if (match) begin
               // Hit: for a lookup or remove, the slot word just read is modified and written back.
               pend_in      = 1'b0;
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               case (cmd_ff)
                  CMD_LOOKUP: begin
                     ram_we         = 1'b1;
                     ram_wdata.hits = rd_entry.hits + COUNT_W'(1);
                     rsp_status_in  = STATUS_OK;
                     rsp_mapped_in  = rd_entry.spare;
                     rsp_count_in   = rd_entry.hits + COUNT_W'(1);
                     if (stats_en_ff) begin
                        hit_tot_in = hit_tot_ff + COUNT_W'(1);
                     end
                  end
                  CMD_ADD: begin
                     rsp_status_in = STATUS_PRESENT;
                  end
                  CMD_REMOVE: begin
                     ram_we          = 1'b1;
                     ram_wdata.valid = 1'b0;
                     rsp_status_in   = STATUS_OK;
                  end
                  default: begin
                  end
               endcase
            end else if (!pend_ff && !issue) begin
               // Every used slot has been checked without a hit.
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               case (cmd_ff)
                  CMD_LOOKUP: begin
                     rsp_status_in = STATUS_MISS;
                     if (stats_en_ff) begin
                        miss_tot_in = miss_tot_ff + COUNT_W'(1);
                     end
                  end
                  CMD_ADD: begin
                     ram_we          = 1'b1;
                     ram_waddr       = used_cnt[IDX_W-1:0];
                     ram_wdata.valid = 1'b1;
                     ram_wdata.hits  = '0;
                     ram_wdata.spare = spare_ff;
                     ram_wdata.key   = key_ff;
                     used_in         = used_ff + USED_W'(1);
                     rsp_status_in   = STATUS_OK;
                  end
                  CMD_REMOVE: begin
                     rsp_status_in = STATUS_MISS;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_COMPACT: begin
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               pend_in   = 1'b1;
               pidx_in   = rd_cnt_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               // The write pointer trails the read pointer, so a valid slot
               // never lands on one still waiting to be read.
               if (rd_entry.valid) begin
                  ram_we    = 1'b1;
                  ram_waddr = wr_cnt_ff[IDX_W-1:0];
                  ram_wdata = rd_entry;
                  wr_cnt_in = wr_cnt_ff + CNT_W'(1);
               end
            end else if (!issue) begin
               used_in       = USED_W'(wr_cnt_ff);
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_cnt_ff    <= '0;
         wr_cnt_ff    <= '0;
         pend_ff      <= 1'b0;
         used_ff      <= '0;
         hit_tot_ff   <= '0;
         miss_tot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         wr_cnt_ff    <= wr_cnt_in;
         pend_ff      <= pend_in;
         used_ff      <= used_in;
         hit_tot_ff   <= hit_tot_in;
         miss_tot_ff  <= miss_tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; the result fields are meaningful while the strobe is high.
   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      key_ff          <= key_in;
      spare_ff        <= spare_in;
      pidx_ff         <= pidx_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_mapped_ff   <= rsp_mapped_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_used_ff     <= used_in;
      rsp_hit_tot_ff  <= hit_tot_in;
      rsp_miss_tot_ff <= miss_tot_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_mapped_sector    = rsp_mapped_ff;
   assign rsp_hit_access_count = rsp_count_ff;
   assign rsp_used_slots       = rsp_used_ff;
   assign rsp_hit_total        = rsp_hit_tot_ff;
   assign rsp_miss_total       = rsp_miss_tot_ff;

   `SRT_ASSERT(a_used_in_range, clock, reset, (used_cnt <= CNT_W'(SLOTS)), "used slots beyond table size")
   `SRT_ASSERT(a_compact_order, clock, reset, (wr_cnt_ff <= rd_cnt_ff), "compaction write passed read")
   `SRT_ASSERT(a_rsp_when_idle, clock, reset, (rsp_valid_ff |-> (state_ff == S_IDLE)), "result while busy")
   `SRT_ASSERT(a_compact_busy, clock, reset, ((start && !busy && (req_command == CMD_COMPACT)) |=> busy), "compaction did not start")
   `SRT_ASSERT(a_total_moves, clock, reset, ((hit_tot_ff != $past(hit_tot_ff)) |-> rsp_valid_ff), "hit total moved without result")

endmodule

// File: rtl/core/srt_ram.sv
module srt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
